// ----- sv/lsmb_pkg.sv -----
// Shared types, constants and the arctangent table of the lidar scan merge binner.
`timescale 1ns / 1ps
package lsmb_pkg;

   localparam int BINS     = 720;
   localparam int BIN_W    = $clog2(BINS);
   localparam int ITERS    = 24;
   localparam int ITER_W   = $clog2(ITERS);
   localparam int QDEPTH   = 4;
   localparam int QPTR_W   = $clog2(QDEPTH);
   localparam int XW       = 40;
   localparam int GAIN_W   = 30;
   localparam logic [GAIN_W-1:0] INV_GAIN  = 30'd652032874;
   localparam logic [15:0]       NO_RETURN = 16'hFFFF;
   localparam logic [15:0]       RANGE_SAT = 16'd65534;

   typedef enum logic [1:0] {
      ACT_CLEAR   = 2'd0,
      ACT_PROJECT = 2'd1,
      ACT_READ    = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      CSR_FRONT_X   = 3'd0,
      CSR_FRONT_Y   = 3'd1,
      CSR_FRONT_YAW = 3'd2,
      CSR_REAR_X    = 3'd3,
      CSR_REAR_Y    = 3'd4,
      CSR_REAR_YAW  = 3'd5
   } csr_index_type;

   typedef struct packed {
      action_type         action;
      logic [15:0]        range;
      logic [15:0]        angle;
      logic signed [15:0] mount_x;
      logic signed [15:0] mount_y;
      logic [9:0]         read_index;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } qhead_type;

   typedef struct packed {
      logic pop;
      logic init;
   } back_status_type;

   function automatic logic [31:0] atan_lookup(input logic [ITER_W-1:0] i);
      logic [31:0] a;
      case (i)
         5'd0:  a = 32'd536870912;
         5'd1:  a = 32'd316933406;
         5'd2:  a = 32'd167458907;
         5'd3:  a = 32'd85004756;
         5'd4:  a = 32'd42667331;
         5'd5:  a = 32'd21354465;
         5'd6:  a = 32'd10679838;
         5'd7:  a = 32'd5340245;
         5'd8:  a = 32'd2670163;
         5'd9:  a = 32'd1335087;
         5'd10: a = 32'd667544;
         5'd11: a = 32'd333772;
         5'd12: a = 32'd166886;
         5'd13: a = 32'd83443;
         5'd14: a = 32'd41722;
         5'd15: a = 32'd20861;
         5'd16: a = 32'd10430;
         5'd17: a = 32'd5215;
         5'd18: a = 32'd2608;
         5'd19: a = 32'd1304;
         5'd20: a = 32'd652;
         5'd21: a = 32'd326;
         5'd22: a = 32'd163;
         5'd23: a = 32'd81;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

endpackage

// ----- sv/lsmb_front.sv -----
// Front end: mount registers, sample validation, beam angle and the job queue.
`timescale 1ns / 1ps
module lsmb_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [1:0]                req_action,
   input  logic                      req_sensor,
   input  logic [11:0]               req_sample_index,
   input  logic [15:0]               req_sample_range,
   input  logic signed [15:0]        req_scan_start_angle,
   input  logic [15:0]               req_scan_angle_step,
   input  logic [15:0]               req_scan_range_low,
   input  logic [15:0]               req_scan_range_high,
   input  logic [9:0]                req_read_index,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [2:0]                csr_index,
   input  logic [15:0]               csr_data,
   input  lsmb_pkg::back_status_type back_status,
   output lsmb_pkg::qhead_type       qhead
);

   logic signed [15:0] front_x_ff, front_y_ff, rear_x_ff, rear_y_ff;
   logic [15:0]        front_yaw_ff, rear_yaw_ff;

   lsmb_pkg::job_type                  queue_ff [lsmb_pkg::QDEPTH];
   logic [lsmb_pkg::QPTR_W-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [lsmb_pkg::QPTR_W:0]          count_ff;

   lsmb_pkg::job_type job;
   logic              accept, keep, do_pop;
   logic [27:0]       step_prod;
   logic [15:0]       yaw;

   assign csr_ready = 1'b1;
   assign req_full  = (count_ff == (lsmb_pkg::QPTR_W+1)'(lsmb_pkg::QDEPTH))
                      | back_status.init;
   assign accept    = req_push & ~req_full;

   always_comb begin
      yaw       = req_sensor ? rear_yaw_ff : front_yaw_ff;
      step_prod = 28'(req_sample_index) * 28'(req_scan_angle_step);
      job.action     = lsmb_pkg::action_type'(req_action);
      job.range      = req_sample_range;
      job.angle      = 16'(req_scan_start_angle) + step_prod[15:0] + yaw;
      job.mount_x    = req_sensor ? rear_x_ff : front_x_ff;
      job.mount_y    = req_sensor ? rear_y_ff : front_y_ff;
      job.read_index = req_read_index;
      case (job.action)
         lsmb_pkg::ACT_CLEAR, lsmb_pkg::ACT_READ: keep = 1'b1;
         lsmb_pkg::ACT_PROJECT: keep = (req_scan_range_low < req_sample_range) &&
                                       (req_sample_range < req_scan_range_high);
         default: keep = 1'b0;
      endcase
   end

   assign do_pop      = back_status.pop & (count_ff != '0);
   assign qhead.valid = (count_ff != '0);
   assign qhead.job   = queue_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (accept && keep) begin
         queue_ff[wr_ptr_ff] <= job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         front_x_ff   <= '0;
         front_y_ff   <= '0;
         front_yaw_ff <= '0;
         rear_x_ff    <= '0;
         rear_y_ff    <= '0;
         rear_yaw_ff  <= '0;
      end else begin
         if (accept && keep) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (lsmb_pkg::QPTR_W+1)'(accept && keep)
                              - (lsmb_pkg::QPTR_W+1)'(do_pop);
         if (csr_valid) begin
            case (lsmb_pkg::csr_index_type'(csr_index))
               lsmb_pkg::CSR_FRONT_X:   front_x_ff   <= csr_data;
               lsmb_pkg::CSR_FRONT_Y:   front_y_ff   <= csr_data;
               lsmb_pkg::CSR_FRONT_YAW: front_yaw_ff <= csr_data;
               lsmb_pkg::CSR_REAR_X:    rear_x_ff    <= csr_data;
               lsmb_pkg::CSR_REAR_Y:    rear_y_ff    <= csr_data;
               lsmb_pkg::CSR_REAR_YAW:  rear_yaw_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

endmodule

// ----- sv/lsmb_back.sv -----
// Back end: CORDIC rotate and vector sequencer, bin memory, clear sweep and result register.
`timescale 1ns / 1ps
module lsmb_back (
   input  logic                      clock,
   input  logic                      reset,
   input  lsmb_pkg::qhead_type       qhead,
   output lsmb_pkg::back_status_type back_status,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [9:0]                rsp_bin_number,
   output logic [15:0]               rsp_bin_range,
   output logic                      rsp_last_bin
);

   typedef enum logic [3:0] {
      ST_SWEEP, ST_IDLE, ST_ROT, ST_ADD, ST_PREP, ST_VEC, ST_MUL1, ST_MUL2,
      ST_SAT, ST_BIN, ST_CMP, ST_RADDR, ST_RDATA
   } state_type;

   localparam int XW = lsmb_pkg::XW;

   state_type                     state_ff, state_in;
   lsmb_pkg::job_type             job_ff, job_in;
   logic signed [XW-1:0]          x_ff, x_in, y_ff, y_in;
   logic signed [31:0]            z_ff, z_in;
   logic [lsmb_pkg::ITER_W-1:0]   iter_ff, iter_in;
   logic [65:0]                   acc_ff, acc_in;
   logic [15:0]                   rr_ff, rr_in;
   logic [lsmb_pkg::BIN_W-1:0]    idx_ff, idx_in, sweep_ff, sweep_in;
   logic                          init_ff, init_in;
   logic                          out_valid_ff, out_valid_in;
   logic [9:0]                    out_num_ff, out_num_in;
   logic [15:0]                   out_range_ff, out_range_in;
   logic                          out_last_ff, out_last_in;

   logic [15:0]                   mem [lsmb_pkg::BINS];
   logic [15:0]                   rd_data_ff;
   logic                          we;
   logic [lsmb_pkg::BIN_W-1:0]    waddr, raddr, idx_calc;
   logic [15:0]                   wdata;

   logic [45:0]                   start_prod;
   logic [31:0]                   za, atan;
   logic signed [XW-1:0]          x0, xs, ys;
   logic [47:0]                   part;
   logic [32+lsmb_pkg::BIN_W-1:0] bin_prod;
   logic                          pop, in_range;

   assign rsp_empty      = ~out_valid_ff;
   assign rsp_bin_number = out_num_ff;
   assign rsp_bin_range  = out_range_ff;
   assign rsp_last_bin   = out_last_ff;
   assign back_status.pop  = pop;
   assign back_status.init = init_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_data_ff <= mem[raddr];
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      iter_in      = iter_ff;
      acc_in       = acc_ff;
      rr_in        = rr_ff;
      idx_in       = idx_ff;
      sweep_in     = sweep_ff;
      init_in      = init_ff;
      out_valid_in = out_valid_ff & ~rsp_pop;
      out_num_in   = out_num_ff;
      out_range_in = out_range_ff;
      out_last_in  = out_last_ff;
      pop          = 1'b0;
      we           = 1'b0;
      waddr        = idx_ff;
      wdata        = rr_ff;

      atan       = lsmb_pkg::atan_lookup(iter_ff);
      xs         = x_ff >>> iter_ff;
      ys         = y_ff >>> iter_ff;
      start_prod = 46'(qhead.job.range) * 46'(lsmb_pkg::INV_GAIN);
      x0         = XW'(start_prod[45:14]);
      za         = {qhead.job.angle, 16'h0000};
      part       = (state_ff == ST_MUL1) ? 48'(x_ff[17:0]) * 48'(lsmb_pkg::INV_GAIN)
                                         : 48'(x_ff[35:18]) * 48'(lsmb_pkg::INV_GAIN);
      bin_prod   = (32+lsmb_pkg::BIN_W)'({~z_ff[31], z_ff[30:0]})
                   * (32+lsmb_pkg::BIN_W)'(lsmb_pkg::BINS);
      idx_calc   = bin_prod[32+lsmb_pkg::BIN_W-1:32];
      in_range   = ({1'b0, job_ff.read_index} < 11'(lsmb_pkg::BINS));
      raddr      = (state_ff == ST_BIN) ? idx_calc
                                        : lsmb_pkg::BIN_W'(job_ff.read_index);

      case (state_ff)
         ST_SWEEP: begin
            we       = 1'b1;
            waddr    = sweep_ff;
            wdata    = lsmb_pkg::NO_RETURN;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == lsmb_pkg::BIN_W'(lsmb_pkg::BINS - 1)) begin
               init_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (qhead.valid) begin
               pop    = 1'b1;
               job_in = qhead.job;
               case (qhead.job.action)
                  lsmb_pkg::ACT_CLEAR: begin
                     sweep_in = '0;
                     state_in = ST_SWEEP;
                  end
                  lsmb_pkg::ACT_PROJECT: begin
                     // pre-rotate by a half turn for the back half-plane
                     if (qhead.job.angle[15] ^ qhead.job.angle[14]) begin
                        x_in = -x0;
                        z_in = {~za[31], za[30:0]};
                     end else begin
                        x_in = x0;
                        z_in = za;
                     end
                     y_in     = '0;
                     iter_in  = '0;
                     state_in = ST_ROT;
                  end
                  default: state_in = ST_RADDR;
               endcase
            end
         end
         ST_ROT: begin
            if (!z_ff[31]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - $signed(atan);
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + $signed(atan);
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == lsmb_pkg::ITER_W'(lsmb_pkg::ITERS - 1)) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            x_in     = x_ff + (XW'(job_ff.mount_x) <<< 16);
            y_in     = y_ff + (XW'(job_ff.mount_y) <<< 16);
            state_in = ST_PREP;
         end
         ST_PREP: begin
            iter_in = '0;
            if (x_ff == '0 && y_ff == '0) begin
               // point at the centre: range zero, bearing zero
               rr_in    = '0;
               z_in     = '0;
               state_in = ST_BIN;
            end else begin
               if (x_ff[XW-1]) begin
                  x_in = -x_ff;
                  y_in = -y_ff;
                  z_in = 32'sh80000000;
               end else begin
                  z_in = '0;
               end
               state_in = ST_VEC;
            end
         end
         ST_VEC: begin
            if (y_ff[XW-1]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - $signed(atan);
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + $signed(atan);
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == lsmb_pkg::ITER_W'(lsmb_pkg::ITERS - 1)) begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            acc_in   = 66'(part) + (66'd1 << 45);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            acc_in   = acc_ff + (66'(part) << 18);
            state_in = ST_SAT;
         end
         ST_SAT: begin
            rr_in    = (acc_ff[65:46] > 20'(lsmb_pkg::RANGE_SAT)) ? lsmb_pkg::RANGE_SAT
                                                                 : acc_ff[61:46];
            state_in = ST_BIN;
         end
         ST_BIN: begin
            idx_in   = idx_calc;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // keep the nearest range in the bin
            if (rr_ff < rd_data_ff) begin
               we = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_RADDR: begin
            state_in = ST_RDATA;
         end
         ST_RDATA: begin
            // hold until the result register is free
            if (!out_valid_in) begin
               out_valid_in = 1'b1;
               out_num_in   = job_ff.read_index;
               out_range_in = in_range ? rd_data_ff : lsmb_pkg::NO_RETURN;
               out_last_in  = (job_ff.read_index == 10'(lsmb_pkg::BINS - 1));
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         init_ff      <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         init_ff      <= init_in;
         out_valid_ff <= out_valid_in;
      end
      job_ff       <= job_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      iter_ff      <= iter_in;
      acc_ff       <= acc_in;
      rr_ff        <= rr_in;
      idx_ff       <= idx_in;
      out_num_ff   <= out_num_in;
      out_range_ff <= out_range_in;
      out_last_ff  <= out_last_in;
   end

endmodule

// ----- sv/lidar_scan_merge_binner.sv -----
// Top level of the two-lidar scan merge binner.
`timescale 1ns / 1ps
// Merges front and rear lidar range samples into 720 nearest-range bearing bins
// around the robot centre. Beats enter a four-deep job queue; samples outside
// their scan's range window and unused action codes are dropped there. A
// projected sample passes through the back end as 24 CORDIC rotate steps,
// 24 CORDIC vector steps, a two-part range multiply and a bin read-modify-write;
// a read waits for the result register to be free, and a clear
// sweeps the bin memory one entry per cycle. After reset the same
// clearing pass runs with full held high; configuration writes are
// taken throughout.
module lidar_scan_merge_binner (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_action,
   input  logic               req_sensor,
   input  logic [11:0]        req_sample_index,
   input  logic [15:0]        req_sample_range,
   input  logic signed [15:0] req_scan_start_angle,
   input  logic [15:0]        req_scan_angle_step,
   input  logic [15:0]        req_scan_range_low,
   input  logic [15:0]        req_scan_range_high,
   input  logic [9:0]         req_read_index,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [9:0]         rsp_bin_number,
   output logic [15:0]        rsp_bin_range,
   output logic               rsp_last_bin,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);

   lsmb_pkg::qhead_type       qhead;
   lsmb_pkg::back_status_type back_status;

   lsmb_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_action           (req_action),
      .req_sensor           (req_sensor),
      .req_sample_index     (req_sample_index),
      .req_sample_range     (req_sample_range),
      .req_scan_start_angle (req_scan_start_angle),
      .req_scan_angle_step  (req_scan_angle_step),
      .req_scan_range_low   (req_scan_range_low),
      .req_scan_range_high  (req_scan_range_high),
      .req_read_index       (req_read_index),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .back_status          (back_status),
      .qhead                (qhead)
   );

   lsmb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .qhead          (qhead),
      .back_status    (back_status),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_bin_number (rsp_bin_number),
      .rsp_bin_range  (rsp_bin_range),
      .rsp_last_bin   (rsp_last_bin)
   );

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the lidar scan merge binner: predicted bin reads against the block.
`timescale 1ns / 1ps
module tb_top;

   typedef struct {
      lsmb_pkg::action_type action;
      logic                 sensor;
      logic [11:0]          sample_index;
      logic [15:0]          sample_range;
      logic [15:0]          start_angle;
      logic [15:0]          angle_step;
      logic [15:0]          range_low;
      logic [15:0]          range_high;
      logic [9:0]           read_index;
   } sample_beat_type;

   typedef struct {
      logic [9:0]  bin_number;
      logic [15:0] bin_range;
      logic        last_bin;
   } bin_read_type;

   localparam int    DRAIN_CYCLES = 3000;
   localparam int    STALL_LIMIT  = 20000;
   localparam longint ARCTAN [lsmb_pkg::ITERS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [9:0]         rsp_bin_number;
   logic [15:0]        rsp_bin_range;
   logic               rsp_last_bin;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [15:0]        csr_data = '0;
   sample_beat_type    beat = '{lsmb_pkg::ACT_NONE, 1'b0, '0, '0, '0, '0, '0, '0, '0};

   sample_beat_type    sample_q[$];
   bin_read_type       bin_read_q[$];
   logic [15:0]        nearest_mm [lsmb_pkg::BINS];
   longint             mount_reg [6];
   int unsigned        touched_bins[$];
   int                 queued_beats = 0;
   int                 sent_beats = 0;
   int                 send_gap = 0;
   int                 pop_stall = 0;
   int                 idle_cycles = 0;
   bit                 no_idle = 1'b0;
   bit                 failed = 1'b0;

   always #10 clock = ~clock;

   lidar_scan_merge_binner u_top (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_action(beat.action), .req_sensor(beat.sensor),
      .req_sample_index(beat.sample_index), .req_sample_range(beat.sample_range),
      .req_scan_start_angle(beat.start_angle), .req_scan_angle_step(beat.angle_step),
      .req_scan_range_low(beat.range_low), .req_scan_range_high(beat.range_high),
      .req_read_index(beat.read_index),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_bin_number(rsp_bin_number),
      .rsp_bin_range(rsp_bin_range), .rsp_last_bin(rsp_last_bin),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data));

   function automatic int draw_gap();
      int p;
      p = $urandom_range(0, 99);
      if (no_idle || p < 55) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 20);
      return $urandom_range(40, 150);
   endfunction

   // Rotate the beam into the robot frame, shift by the mount, then find range and bin.
   function automatic void locate_point(input logic sensor, input logic [15:0] r,
                                        input logic [15:0] ang, output int unsigned idx,
                                        output logic [15:0] rng);
      longint      x, y, nx, ny, z, bx, by;
      logic [31:0] za, bz;
      logic [63:0] prod;
      x = (longint'(r) * 652032874) >>> 14;
      y = 0;
      za = {ang, 16'h0};
      if (((za + 32'h4000_0000) & 32'h8000_0000) != 0) begin
         x = -x;
         za = za - 32'h8000_0000;
      end
      z = longint'($signed(za));
      for (int i = 0; i < lsmb_pkg::ITERS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i); ny = y + (x >>> i); z -= ARCTAN[i];
         end else begin
            nx = x + (y >>> i); ny = y - (x >>> i); z += ARCTAN[i];
         end
         x = nx; y = ny;
      end
      bx = x + mount_reg[sensor ? lsmb_pkg::CSR_REAR_X : lsmb_pkg::CSR_FRONT_X] * 65536;
      by = y + mount_reg[sensor ? lsmb_pkg::CSR_REAR_Y : lsmb_pkg::CSR_FRONT_Y] * 65536;
      bz = '0;
      if (bx == 0 && by == 0) begin
         rng = '0;
      end else begin
         if (bx < 0) begin
            bx = -bx; by = -by; bz = 32'h8000_0000;
         end
         for (int i = 0; i < lsmb_pkg::ITERS; i++) begin
            if (by < 0) begin
               nx = bx - (by >>> i); ny = by + (bx >>> i); bz = bz - ARCTAN[i][31:0];
            end else begin
               nx = bx + (by >>> i); ny = by - (bx >>> i); bz = bz + ARCTAN[i][31:0];
            end
            bx = nx; by = ny;
         end
         prod = (64'(bx) * 64'd652032874 + 64'h2000_0000_0000) >> 46;
         rng = (prod > 64'(lsmb_pkg::RANGE_SAT)) ? lsmb_pkg::RANGE_SAT : prod[15:0];
      end
      idx = int'((64'(bz ^ 32'h8000_0000) * 64'd720) >> 32);
   endfunction

   function automatic logic [15:0] beam_angle(input sample_beat_type b);
      logic [15:0] yaw;
      yaw = mount_reg[b.sensor ? lsmb_pkg::CSR_REAR_YAW : lsmb_pkg::CSR_FRONT_YAW][15:0];
      return b.start_angle + b.sample_index * b.angle_step + yaw;
   endfunction

   function automatic void update_bins(input sample_beat_type b);
      int unsigned idx;
      logic [15:0] rng;
      case (b.action)
         lsmb_pkg::ACT_CLEAR: foreach (nearest_mm[i]) nearest_mm[i] = lsmb_pkg::NO_RETURN;
         lsmb_pkg::ACT_PROJECT: begin
            if (b.range_low < b.sample_range && b.sample_range < b.range_high) begin
               locate_point(b.sensor, b.sample_range, beam_angle(b), idx, rng);
               if (idx < lsmb_pkg::BINS && rng < nearest_mm[idx]) nearest_mm[idx] = rng;
            end
         end
         lsmb_pkg::ACT_READ: begin
            if (b.read_index < lsmb_pkg::BINS)
               bin_read_q.push_back('{b.read_index, nearest_mm[b.read_index],
                                      b.read_index == lsmb_pkg::BINS - 1});
            else
               bin_read_q.push_back('{b.read_index, lsmb_pkg::NO_RETURN, 1'b0});
         end
         default: ;
      endcase
   endfunction

   // Driver: hold a beat until taken, then advance after a random gap.
   always @(posedge clock) begin
      bit drive;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         drive = req_push;
         if (req_push && !req_full) begin
            update_bins(beat);
            sent_beats++;
            drive = 1'b0;
         end
         if (!drive) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (sample_q.size() > 0) begin
               beat <= sample_q.pop_front();
               drive = 1'b1;
               send_gap = draw_gap();
            end
         end
         req_push <= drive;
      end
   end

   // Monitor: check each read beat against the oldest prediction.
   always @(posedge clock) begin
      bin_read_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (bin_read_q.size() == 0) begin
               $display("%0t: unexpected read beat bin %0d range %0d", $realtime,
                        rsp_bin_number, rsp_bin_range);
               failed = 1'b1;
            end else begin
               want = bin_read_q.pop_front();
               if (rsp_bin_number !== want.bin_number) begin
                  $display("%0t: bin_number expected %0d actual %0d", $realtime,
                           want.bin_number, rsp_bin_number);
                  failed = 1'b1;
               end
               if (rsp_bin_range !== want.bin_range) begin
                  $display("%0t: bin_range of bin %0d expected %0d actual %0d", $realtime,
                           want.bin_number, want.bin_range, rsp_bin_range);
                  failed = 1'b1;
               end
               if (rsp_last_bin !== want.last_bin) begin
                  $display("%0t: last_bin of bin %0d expected %0d actual %0d", $realtime,
                           want.bin_number, want.last_bin, rsp_last_bin);
                  failed = 1'b1;
               end
            end
            pop_stall = draw_gap();
         end
         if (pop_stall > 0) begin
            pop_stall--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic queue_beat(input sample_beat_type b);
      sample_q.push_back(b);
      queued_beats++;
   endtask

   task automatic queue_read(input logic [9:0] ridx);
      sample_beat_type b;
      b = '{lsmb_pkg::ACT_READ, 1'($urandom_range(0, 1)), 12'($urandom), 16'($urandom),
            16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), ridx};
      queue_beat(b);
   endtask

   // Queue a sample and remember the bin it should land in.
   task automatic queue_sample(input sample_beat_type b);
      int unsigned idx;
      logic [15:0] rng;
      if (b.action == lsmb_pkg::ACT_PROJECT && b.range_low < b.sample_range &&
          b.sample_range < b.range_high) begin
         locate_point(b.sensor, b.sample_range, beam_angle(b), idx, rng);
         if (idx < lsmb_pkg::BINS) touched_bins.push_back(idx);
      end
      queue_beat(b);
   endtask

   task automatic write_mounts(input longint val [6]);
      csr_valid <= 1'b1;
      for (int i = 0; i < 6; i++) begin
         csr_index <= 3'(i);
         csr_data <= val[i][15:0];
         do @(posedge clock); while (!csr_ready);
         mount_reg[i] = longint'($signed(val[i][15:0]));
      end
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      wait (queued_beats == sent_beats && bin_read_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_scan();
      sample_beat_type b;
      logic        sensor;
      logic [15:0] start, step, lo, hi;
      int          n;
      sensor = 1'($urandom_range(0, 1));
      start = 16'($urandom);
      step = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
      lo = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
      hi = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(lo, 65535));
      if (hi < lo + 2) hi = 16'hFFFF;
      if (lo > 65000) lo = 16'($urandom_range(0, 300));
      touched_bins.delete();
      if ($urandom_range(0, 9) == 0)
         queue_beat('{lsmb_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0});
      n = $urandom_range(10, 40);
      for (int i = 0; i < n; i++) begin
         b = '{lsmb_pkg::ACT_PROJECT, sensor, 12'($urandom),
               16'($urandom_range(lo + 1, hi - 1)), start, step, lo, hi, 10'($urandom)};
         if ($urandom_range(0, 7) == 0) begin
            // noise: any action, any fields; most projections fall outside their window
            b = '{lsmb_pkg::action_type'($urandom_range(0, 3)), 1'($urandom),
                  12'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 10'($urandom)};
            if (b.action == lsmb_pkg::ACT_READ && $urandom_range(0, 1))
               b.read_index = 10'(lsmb_pkg::BINS - 1);
         end
         queue_sample(b);
      end
      n = $urandom_range(5, 20);
      for (int i = 0; i < n; i++) begin
         if (touched_bins.size() > 0 && $urandom_range(0, 9) < 7)
            queue_read(10'(touched_bins[$urandom_range(0, touched_bins.size() - 1)]));
         else
            queue_read(10'($urandom_range(0, 1023)));
      end
   endtask

   initial begin
      longint setting [6];
      foreach (nearest_mm[i]) nearest_mm[i] = lsmb_pkg::NO_RETURN;
      foreach (mount_reg[i]) mount_reg[i] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: bin extremes, window edges, angle quadrant edges, unused action
      queue_beat('{lsmb_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0});
      queue_read(10'd0);
      queue_read(10'(lsmb_pkg::BINS - 1));
      queue_read(10'(lsmb_pkg::BINS));
      queue_read(10'h3FF);
      queue_sample('{lsmb_pkg::ACT_PROJECT, 0, 0, 1000, 0, 0, 0, 16'hFFFF, 0});
      queue_sample('{lsmb_pkg::ACT_PROJECT, 1, 0, 65534, 16'h8000, 0, 0, 16'hFFFF, 0});
      queue_sample('{lsmb_pkg::ACT_PROJECT, 0, 0, 2000, 16'h4000, 0, 100, 3000, 0});
      queue_sample('{lsmb_pkg::ACT_PROJECT, 1, 12'hFFF, 1, 16'h7FFF, 16'hFFFF, 0, 2, 0});
      queue_sample('{lsmb_pkg::ACT_PROJECT, 0, 0, 500, 0, 0, 500, 900, 0});
      queue_sample('{lsmb_pkg::ACT_PROJECT, 0, 0, 900, 0, 0, 500, 900, 0});
      queue_sample('{lsmb_pkg::ACT_PROJECT, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0});
      queue_sample('{lsmb_pkg::ACT_NONE, 1, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0,
                     16'hFFFF, 0});
      foreach (touched_bins[i]) queue_read(10'(touched_bins[i]));
      queue_beat('{lsmb_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0});
      foreach (touched_bins[i]) queue_read(10'(touched_bins[i]));

      for (int ph = 0; ph < 5; ph++) begin
         if (ph > 0) begin
            wait_idle();
            foreach (setting[i]) begin
               case (ph)
                  1: setting[i] = 32767;
                  2: setting[i] = -32768;
                  default: setting[i] = (i == lsmb_pkg::CSR_FRONT_YAW ||
                                         i == lsmb_pkg::CSR_REAR_YAW) ?
                                        longint'($urandom_range(0, 65535)) :
                                        longint'($urandom_range(0, 1000)) - 500;
               endcase
            end
            write_mounts(setting);
         end
         no_idle = (ph == 2);
         while (queued_beats < (ph + 1) * 380) random_scan();
      end

      wait_idle();
      if (!failed)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
